>>> rtl/imc_pkg.sv
// Shared types and constants of the unfolding read port.
`default_nettype none
package imc_pkg;

  // Item opcodes on in_mode.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_STRIDE_W     = 3'd0;
  localparam logic [2:0] CFG_STRIDE_H     = 3'd1;
  localparam logic [2:0] CFG_PAD_W        = 3'd2;
  localparam logic [2:0] CFG_PAD_H        = 3'd3;
  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd5;
  localparam logic [2:0] CFG_ZERO_VALUE   = 3'd6;

  // Geometry registers that the address stage needs.
  typedef struct packed {
    logic [3:0] stride_w;
    logic [3:0] stride_h;
    logic [3:0] pad_w;
    logic [3:0] pad_h;
    logic [6:0] image_width;
    logic [6:0] image_height;
  } geom_cfg_t;

  // Memory command issued by the address stage for one beat.
  typedef struct packed {
    logic rd;   // read beat heading for the output
    logic wr;   // pixel write into the store
    logic pad;  // source position lies outside the image
  } mem_ctl_t;

endpackage
`default_nettype wire

>>> rtl/imc_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module imc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                       wdata,
  output      logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; read data is registered.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/imc_addr_gen.sv
// Source position, bounds check and store address generation.
`default_nettype none
module imc_addr_gen
  import imc_pkg::*;
#(
  parameter int MAX_PLANES = 8,
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int DEPTH      = MAX_PLANES * MAX_HEIGHT * MAX_WIDTH,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic           mode,
  input  wire logic [2:0]     plane,
  input  wire logic [5:0]     pixel_row,
  input  wire logic [5:0]     pixel_col,
  input  wire logic [7:0]     pixel_value,
  input  wire logic [3:0]     kernel_row,
  input  wire logic [3:0]     kernel_col,
  input  wire logic [5:0]     out_row,
  input  wire logic [5:0]     out_col,
  input  wire geom_cfg_t      cfg,
  output      mem_ctl_t       ctl,
  output      logic [AW-1:0]  addr,
  output      logic [7:0]     wdata
);

  localparam logic signed [11:0] MaxP = 12'(MAX_PLANES);
  localparam logic signed [11:0] MaxW = 12'(MAX_WIDTH);
  localparam logic signed [11:0] MaxH = 12'(MAX_HEIGHT);

  logic        valid_r;
  logic        mode_r;
  logic [2:0]  plane_r;
  logic [5:0]  pixel_row_r;
  logic [5:0]  pixel_col_r;
  logic [7:0]  pixel_value_r;
  logic [3:0]  kernel_row_r;
  logic [3:0]  kernel_col_r;
  logic [9:0]  prod_row_r;
  logic [9:0]  prod_col_r;

  logic signed [11:0] src_row;
  logic signed [11:0] src_col;
  logic signed [11:0] sel_row;
  logic signed [11:0] sel_col;
  logic signed [11:0] plane_ext;
  logic               row_in;
  logic               col_in;
  logic               plane_in;
  logic               src_ok;

  // First stage: take the beat and form the stride products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r        <= mode;
      plane_r       <= plane;
      pixel_row_r   <= pixel_row;
      pixel_col_r   <= pixel_col;
      pixel_value_r <= pixel_value;
      kernel_row_r  <= kernel_row;
      kernel_col_r  <= kernel_col;
      prod_row_r    <= 10'(out_row) * 10'(cfg.stride_h);
      prod_col_r    <= 10'(out_col) * 10'(cfg.stride_w);
    end
  end

  // Second stage: source position, bounds and address.
  always_comb begin
    src_row = $signed({2'b00, prod_row_r}) - $signed({8'd0, cfg.pad_h})
              + $signed({8'd0, kernel_row_r});
    src_col = $signed({2'b00, prod_col_r}) - $signed({8'd0, cfg.pad_w})
              + $signed({8'd0, kernel_col_r});

    if (mode_r == MODE_READ) begin
      sel_row = src_row;
      sel_col = src_col;
    end else begin
      sel_row = $signed({6'd0, pixel_row_r});
      sel_col = $signed({6'd0, pixel_col_r});
    end

    plane_ext = $signed({9'd0, plane_r});
    plane_in  = plane_ext < MaxP;
    row_in    = (sel_row >= 12'sd0) && (sel_row < MaxH);
    col_in    = (sel_col >= 12'sd0) && (sel_col < MaxW);

    // Reads are also bounded by the configured image size.
    if (mode_r == MODE_READ) begin
      src_ok = plane_in && row_in && col_in &&
               (sel_row < $signed({5'd0, cfg.image_height})) &&
               (sel_col < $signed({5'd0, cfg.image_width}));
    end else begin
      src_ok = plane_in && row_in && col_in;
    end

    ctl.rd  = valid_r && (mode_r == MODE_READ);
    ctl.wr  = valid_r && (mode_r == MODE_WRITE) && src_ok;
    ctl.pad = !src_ok;

    addr = (AW'(plane_r) * AW'(MAX_HEIGHT) + AW'(sel_row[10:0])) * AW'(MAX_WIDTH)
           + AW'(sel_col[10:0]);
    wdata = pixel_value_r;
  end

endmodule
`default_nettype wire

>>> rtl/im2col_unfold_padded_unit.sv
// Top level of the im2col unfolding read port with zero padding.
//
// Usage: an input beat is taken at a clock edge with start high and busy
// low. busy never rises, so one beat may be offered in every cycle. A beat
// with in_mode = write stores in_pixel_value at (plane, row, column) and
// gives no result. A beat with in_mode = read names one element of the
// unfolded matrix; the source row is out_row * stride_h - pad_h +
// kernel_row, the column likewise. The result beat (out_element_value,
// out_is_padding) is shown for one cycle with out_strobe high. Sources
// outside the image answer zero_value with out_is_padding set. Throughput
// is one beat per cycle, set by the single port of the image memory, which
// all beats pass in order, so a read always sees every earlier write. The
// receiver cannot stall the result channel. Synchronous reset clears the
// pipeline valid bits and loads the register defaults; the image memory
// is not cleared and each pixel must be written before it is read.
// Configuration writes take effect at once; the user must make them only
// while no beat is in flight, as the block does not enforce it.
`default_nettype none
module im2col_unfold_padded_unit
  import imc_pkg::*;
#(
  parameter int MAX_PLANES = 8,
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output      logic       busy,
  input  wire logic       in_mode,
  input  wire logic [2:0] in_plane,
  input  wire logic [5:0] in_pixel_row,
  input  wire logic [5:0] in_pixel_col,
  input  wire logic [7:0] in_pixel_value,
  input  wire logic [3:0] in_kernel_row,
  input  wire logic [3:0] in_kernel_col,
  input  wire logic [5:0] in_out_row,
  input  wire logic [5:0] in_out_col,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  output      logic       out_strobe,
  output      logic [7:0] out_element_value,
  output      logic       out_is_padding
);

  localparam int DEPTH = MAX_PLANES * MAX_HEIGHT * MAX_WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  geom_cfg_t     geom_r;
  logic [7:0]    zero_value_r;
  logic          accept;
  mem_ctl_t      ctl;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;
  logic          rd_valid_r;
  logic          rd_pad_r;
  logic          out_strobe_r;
  logic [7:0]    out_value_r;
  logic          out_pad_r;

  // The pipeline takes a beat in every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.stride_w     <= 4'd1;
      geom_r.stride_h     <= 4'd1;
      geom_r.pad_w        <= 4'd0;
      geom_r.pad_h        <= 4'd0;
      geom_r.image_width  <= 7'd64;
      geom_r.image_height <= 7'd64;
      zero_value_r        <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STRIDE_W:     geom_r.stride_w     <= cfg_wdata[3:0];
        CFG_STRIDE_H:     geom_r.stride_h     <= cfg_wdata[3:0];
        CFG_PAD_W:        geom_r.pad_w        <= cfg_wdata[3:0];
        CFG_PAD_H:        geom_r.pad_h        <= cfg_wdata[3:0];
        CFG_IMAGE_WIDTH:  geom_r.image_width  <= cfg_wdata[6:0];
        CFG_IMAGE_HEIGHT: geom_r.image_height <= cfg_wdata[6:0];
        CFG_ZERO_VALUE:   zero_value_r        <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Address generation over the first two stages.
  imc_addr_gen #(
    .MAX_PLANES (MAX_PLANES),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_addr_gen (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .mode        (in_mode),
    .plane       (in_plane),
    .pixel_row   (in_pixel_row),
    .pixel_col   (in_pixel_col),
    .pixel_value (in_pixel_value),
    .kernel_row  (in_kernel_row),
    .kernel_col  (in_kernel_col),
    .out_row     (in_out_row),
    .out_col     (in_out_col),
    .cfg         (geom_r),
    .ctl         (ctl),
    .addr        (mem_addr),
    .wdata       (mem_wdata)
  );

  // Image store: one read or write per cycle, in beat order.
  imc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_image_store (
    .clk   (clk),
    .en    (ctl.wr || (ctl.rd && !ctl.pad)),
    .we    (ctl.wr),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Track read beats alongside the memory latency.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= ctl.rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_pad_r <= ctl.pad;
  end

  // Output register: padded beats take the configured zero code.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= rd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= rd_pad_r ? zero_value_r : mem_rdata;
    out_pad_r   <= rd_pad_r;
  end

  assign out_strobe        = out_strobe_r;
  assign out_element_value = out_value_r;
  assign out_is_padding    = out_pad_r;

endmodule
`default_nettype wire
